### rtl/tekp_pkg.sv
`default_nettype none
package tekp_pkg;

	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_ARROW = 2'd1;
	localparam logic [1:0] KIND_ALT   = 2'd2;
	localparam logic [1:0] KIND_RAW   = 2'd3;

	localparam logic [7:0] ESC_BYTE      = 8'h1b;
	localparam logic [7:0] CHAR_LBRACKET = 8'h5b;
	localparam logic [7:0] CHAR_UPPER_O  = 8'h4f;
	localparam logic [7:0] CHAR_TILDE    = 8'h7e;
	localparam logic [7:0] CHAR_ZERO     = 8'h30;
	localparam logic [7:0] CHAR_ONE      = 8'h31;
	localparam logic [7:0] CHAR_THREE    = 8'h33;
	localparam logic [7:0] CHAR_NINE     = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
	localparam logic [7:0] CHAR_UPPER_D  = 8'h44;
	localparam logic [7:0] CHAR_UPPER_Z  = 8'h5a;
	localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z  = 8'h7a;

	typedef struct packed {
		logic take;
		logic load_single;
		logic run_start;
		logic run_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic single;
		logic run;
		logic run_last;
	} dp_status_t;

endpackage
`default_nettype wire

### rtl/tekp_in_if.sv
`default_nettype none
interface tekp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

### rtl/tekp_out_if.sv
`default_nettype none
interface tekp_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [7:0] key_value;
	logic [7:0] raw_byte;
	logic       has_raw;
	logic       truncated;
	logic       last;

	modport source (output valid, output event_kind, output key_value, output raw_byte,
		output has_raw, output truncated, output last, input ready);
	modport sink (input valid, input event_kind, input key_value, input raw_byte,
		input has_raw, input truncated, input last, output ready);
endinterface
`default_nettype wire

### rtl/tekp_ctrl.sv
`default_nettype none
module tekp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  tekp_pkg::dp_status_t  status,
	output tekp_pkg::ctl_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		in_ready        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready        = out_free;
				cmd.take        = in_valid && out_free;
				cmd.load_single = cmd.take && status.single;
				cmd.run_start   = cmd.take && status.run;
				if (cmd.run_start) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.run_load = out_free;
				if (out_free && status.run_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		out_valid_d = (cmd.load_single || cmd.run_load) ? 1'b1 : (out_valid_q && !out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule
`default_nettype wire

### rtl/tekp_datapath.sv
`default_nettype none
module tekp_datapath #(
	parameter int SEQ_CAPACITY = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            in_byte,
	input  tekp_pkg::ctl_cmd_t    cmd,
	output tekp_pkg::dp_status_t  status,
	output logic [1:0]            event_kind,
	output logic [7:0]            key_value,
	output logic [7:0]            raw_byte,
	output logic                  has_raw,
	output logic                  truncated,
	output logic                  last
);

	localparam int LEN_W = $clog2(SEQ_CAPACITY + 1);
	localparam int IDX_W = $clog2(SEQ_CAPACITY);

	logic [7:0]       mem [SEQ_CAPACITY];

	logic             in_seq_q;
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic [7:0]       lead_q;
	logic [7:0]       dir_q;

	logic [LEN_W-1:0] run_len_q;
	logic [IDX_W-1:0] run_idx_q;
	logic [1:0]       run_kind_q;
	logic [7:0]       run_key_q;
	logic             run_trunc_q;

	logic [1:0]       kind_q;
	logic [7:0]       key_q;
	logic [7:0]       raw_q;
	logic             has_raw_q;
	logic             trunc_q;
	logic             last_q;

	logic             is_esc, is_digit, is_alt, is_term;
	logic             has_room;
	logic [LEN_W-1:0] len_new;
	logic [7:0]       dir_eff;
	logic             lead_ok, dir_ok;
	logic             digit_end, term_end, arrow;
	logic             run_last;

	always_comb begin
		is_esc   = in_byte == tekp_pkg::ESC_BYTE;
		is_digit = in_byte inside {[tekp_pkg::CHAR_ZERO:tekp_pkg::CHAR_NINE]};
		is_alt   = in_byte inside {[tekp_pkg::CHAR_ONE:tekp_pkg::CHAR_THREE]};
		is_term  = (in_byte inside {[tekp_pkg::CHAR_LOWER_A:tekp_pkg::CHAR_LOWER_Z]})
			|| ((in_byte inside {[tekp_pkg::CHAR_UPPER_A:tekp_pkg::CHAR_UPPER_Z]})
				&& in_byte != tekp_pkg::CHAR_UPPER_O)
			|| in_byte == tekp_pkg::CHAR_TILDE;
		has_room = len_q != LEN_W'(SEQ_CAPACITY);
		len_new  = has_room ? len_q + LEN_W'(1) : len_q;
		// the direction byte lands at index two, possibly with this very transaction
		dir_eff  = (len_q == LEN_W'(2)) ? in_byte : dir_q;
		lead_ok  = lead_q == tekp_pkg::CHAR_LBRACKET || lead_q == tekp_pkg::CHAR_UPPER_O;
		dir_ok   = dir_eff inside {[tekp_pkg::CHAR_UPPER_A:tekp_pkg::CHAR_UPPER_D]};

		digit_end = in_seq_q && !is_esc && len_q == LEN_W'(1) && is_digit;
		term_end  = in_seq_q && !is_esc && !digit_end && is_term;
		arrow     = term_end && len_new >= LEN_W'(3) && lead_ok && dir_ok;
		run_last  = (LEN_W'(run_idx_q) + LEN_W'(1)) == run_len_q;

		status.single   = !is_esc && (!in_seq_q || (digit_end && is_alt));
		status.run      = (is_esc && in_seq_q) || (digit_end && !is_alt) || term_end;
		status.run_last = run_last;
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_seq_q <= 1'b0;
			len_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (cmd.take) begin
			if (is_esc) begin
				in_seq_q <= 1'b1;
				len_q    <= LEN_W'(1);
				ovf_q    <= 1'b0;
			end else if (in_seq_q) begin
				if (digit_end || term_end) begin
					in_seq_q <= 1'b0;
					len_q    <= '0;
					ovf_q    <= 1'b0;
				end else if (has_room) begin
					len_q <= len_new;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (is_esc) begin
				mem[0] <= in_byte;
			end else if (in_seq_q && has_room) begin
				mem[len_q[IDX_W-1:0]] <= in_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && !is_esc && in_seq_q) begin
			if (len_q == LEN_W'(1)) begin
				lead_q <= in_byte;
			end
			if (len_q == LEN_W'(2)) begin
				dir_q <= in_byte;
			end
		end
	end

	// run parameters come from the state before this transaction updates it
	always_ff @(posedge clk) begin
		if (cmd.run_start) begin
			run_len_q   <= is_esc ? len_q : len_new;
			run_trunc_q <= is_esc ? ovf_q : (ovf_q || !has_room);
			run_kind_q  <= arrow ? tekp_pkg::KIND_ARROW : tekp_pkg::KIND_RAW;
			run_key_q   <= arrow ? (dir_eff - tekp_pkg::CHAR_UPPER_A) : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_idx_q <= '0;
		end else if (cmd.run_start) begin
			run_idx_q <= '0;
		end else if (cmd.run_load) begin
			run_idx_q <= run_idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run_load) begin
			kind_q    <= run_kind_q;
			key_q     <= run_key_q;
			raw_q     <= mem[run_idx_q];
			has_raw_q <= 1'b1;
			trunc_q   <= run_trunc_q;
			last_q    <= run_last;
		end else if (cmd.load_single) begin
			if (in_seq_q) begin
				kind_q    <= tekp_pkg::KIND_ALT;
				key_q     <= in_byte - tekp_pkg::CHAR_ZERO;
				raw_q     <= 8'd0;
				has_raw_q <= 1'b0;
			end else begin
				kind_q    <= tekp_pkg::KIND_PLAIN;
				key_q     <= in_byte;
				raw_q     <= in_byte;
				has_raw_q <= 1'b1;
			end
			trunc_q <= 1'b0;
			last_q  <= 1'b1;
		end
	end

	assign event_kind = kind_q;
	assign key_value  = key_q;
	assign raw_byte   = raw_q;
	assign has_raw    = has_raw_q;
	assign truncated  = trunc_q;
	assign last       = last_q;

endmodule
`default_nettype wire

### rtl/terminal_escape_key_parser_top.sv
`default_nettype none
// Terminal escape key parser: one terminal byte per transaction on byte_ch, key events
// on event_ch as runs of items, the final item of each run marked by last. A byte that
// produces a plain key or an alt digit, or that is only collected into an escape
// sequence, is taken when the output register is free, so such bytes stream at one per
// cycle unless event_ch stalls. A byte that closes a sequence (or an ESC that flushes
// one) starts a run of n items, n being the number of stored sequence bytes, at most
// SEQ_CAPACITY; the sequence buffer has one read port and gives one byte per cycle
// unless event_ch stalls; byte_ch waits out the run. No clearing pass follows reset.
module terminal_escape_key_parser_top #(
	parameter int SEQ_CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	tekp_in_if.sink     byte_ch,
	tekp_out_if.source  event_ch
);

	tekp_pkg::ctl_cmd_t   cmd;
	tekp_pkg::dp_status_t status;

	tekp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (byte_ch.valid),
		.in_ready  (byte_ch.ready),
		.out_valid (event_ch.valid),
		.out_ready (event_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	tekp_datapath #(
		.SEQ_CAPACITY (SEQ_CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (byte_ch.in_byte),
		.cmd        (cmd),
		.status     (status),
		.event_kind (event_ch.event_kind),
		.key_value  (event_ch.key_value),
		.raw_byte   (event_ch.raw_byte),
		.has_raw    (event_ch.has_raw),
		.truncated  (event_ch.truncated),
		.last       (event_ch.last)
	);

endmodule
`default_nettype wire
